[rtl/pdlb_pkg.sv]
// shared types, constants and the blend function for the palette delay-line blend
// no dependencies; every module of the block imports this package
package pdlb_pkg;

  // line store geometry
  localparam int MAX_LINE = 512;
  localparam int COL_W    = $clog2(MAX_LINE);
  localparam int LW_W     = 10;
  localparam int WCMP_W   = (COL_W + 1 > LW_W) ? COL_W + 1 : LW_W;

  // palette geometry
  localparam int IDX_W    = 8;
  localparam int PAL_AW   = IDX_W + 1;
  localparam int COLOUR_W = 32;

  // configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_LINE_WIDTH   = 2'd0;
  localparam cfg_idx_t CFG_START_PARITY = 2'd1;
  localparam cfg_idx_t CFG_AVERAGE_MASK = 2'd2;

  // configuration reset values
  localparam logic [LW_W-1:0]     LINE_WIDTH_RST   = 10'd384;
  localparam logic                START_PARITY_RST = 1'b0;
  localparam logic [COLOUR_W-1:0] AVG_MASK_RST     = 32'hFEFE_FEFE;

  // index nibble masks
  localparam logic [IDX_W-1:0] HUE_MASK  = 8'hF0;
  localparam logic [IDX_W-1:0] LUMA_MASK = 8'h0F;

  // request kinds
  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_TABLE = 1'b1
  } req_t;

  // per-pixel raster control handed from the sequencer to the pipeline
  typedef struct packed {
    logic parity;
    logic first;
    logic last;
  } pix_ctl_t;

  // masked halving add per channel
  function automatic logic [COLOUR_W-1:0] blend_colour(
    input logic [COLOUR_W-1:0] a,
    input logic [COLOUR_W-1:0] b,
    input logic [COLOUR_W-1:0] mask
  );
    logic [COLOUR_W-1:0] half;
    half = ((a ^ b) & mask) >> 1;
    return (a & b) + half;
  endfunction

endpackage

[rtl/pdlb_palette.sv]
// dual palette memory: 512 x 32, one write port and two registered read ports
// depends on pdlb_pkg
module pdlb_palette (
  input  logic                            clk,
  input  logic                            we,
  input  logic [pdlb_pkg::PAL_AW-1:0]     waddr,
  input  logic [pdlb_pkg::COLOUR_W-1:0]   wdata,
  input  logic                            re,
  input  logic [pdlb_pkg::PAL_AW-1:0]     raddr_a,
  input  logic [pdlb_pkg::PAL_AW-1:0]     raddr_b,
  output logic [pdlb_pkg::COLOUR_W-1:0]   rdata_a,
  output logic [pdlb_pkg::COLOUR_W-1:0]   rdata_b
);
  import pdlb_pkg::*;

  logic [COLOUR_W-1:0] mem [2**PAL_AW];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports, data held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

[rtl/pdlb_line_store.sv]
// previous-line index store, read-before-write at the same column
// depends on pdlb_pkg
module pdlb_line_store (
  input  logic                         clk,
  input  logic                         en,
  input  logic [pdlb_pkg::COL_W-1:0]   addr,
  input  logic [pdlb_pkg::IDX_W-1:0]   wdata,
  output logic [pdlb_pkg::IDX_W-1:0]   rdata
);
  import pdlb_pkg::*;

  logic [IDX_W-1:0] mem [MAX_LINE];

  // old entry comes out while the current pixel replaces it
  always_ff @(posedge clk) begin
    if (en) begin
      rdata     <= mem[addr];
      mem[addr] <= wdata;
    end
  end

endmodule

[rtl/pdlb_raster_ctl.sv]
// raster sequencer: column, line parity, first-line and line-end flags per pixel
// depends on pdlb_pkg
module pdlb_raster_ctl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        acc_pix,
  input  logic                        frame_start,
  input  logic [pdlb_pkg::LW_W-1:0]   line_width,
  input  logic                        start_parity,
  output logic [pdlb_pkg::COL_W-1:0]  col,
  output pdlb_pkg::pix_ctl_t          ctl
);
  import pdlb_pkg::*;

  logic [COL_W-1:0]  col_r, col_nxt;
  logic              par_r, par_nxt;
  logic              first_r, first_nxt;
  logic [WCMP_W-1:0] lw_ext, eff_w, col_p1;

  // frame start overrides the running position; clamp the line width to
  // 1..MAX_LINE and detect the line end
  always_comb begin
    col        = frame_start ? '0 : col_r;
    ctl.parity = frame_start ? start_parity : par_r;
    ctl.first  = frame_start | first_r;
    lw_ext = WCMP_W'(line_width);
    priority if (lw_ext == '0) begin
      eff_w = WCMP_W'(1);
    end else if (lw_ext > WCMP_W'(MAX_LINE)) begin
      eff_w = WCMP_W'(MAX_LINE);
    end else begin
      eff_w = lw_ext;
    end
    col_p1   = WCMP_W'(col) + WCMP_W'(1);
    ctl.last = (col_p1 >= eff_w);
  end

  // next position
  always_comb begin
    if (ctl.last) begin
      col_nxt   = '0;
      par_nxt   = ~ctl.parity;
      first_nxt = 1'b0;
    end else begin
      col_nxt   = col_p1[COL_W-1:0];
      par_nxt   = ctl.parity;
      first_nxt = ctl.first;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      par_r   <= START_PARITY_RST;
      first_r <= 1'b1;
    end else if (acc_pix) begin
      col_r   <= col_nxt;
      par_r   <= par_nxt;
      first_r <= first_nxt;
    end
  end

  // a line end always rewinds the column
  a_last_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    acc_pix && ctl.last |=> col_r == '0 && !first_r)
    else $error("column not rewound after line end");

  // mid-line pixels keep parity
  a_parity_held: assert property (@(posedge clk) disable iff (!rst_n)
    acc_pix && !ctl.last |=> par_r == $past(ctl.parity))
    else $error("parity changed mid-line");

  // idle cycles leave the position alone
  a_col_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !acc_pix |=> $stable(col_r))
    else $error("column moved without a pixel");

endmodule

[rtl/pal_delay_line_blend_top.sv]
// an accepted pixel passes stage 1, the palette read registers and the output register
// throughput: 1 item per cycle while out_stall is low; each stage reads its memory
// once per item (line store in stage 1, both palette ports in stage 2), blend registered at the output
// palette writes yield no result and take the same pipeline slot as a pixel
// reset (rst_n low, synchronous): pipeline empty, column 0, first line set, config defaults
// memories are not cleared; unwritten entries read undefined
module pal_delay_line_blend_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_we,
  input  pdlb_pkg::cfg_idx_t              cfg_index,
  input  logic [pdlb_pkg::COLOUR_W-1:0]   cfg_wdata,
  // input items
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_req_type,
  input  logic [pdlb_pkg::IDX_W-1:0]      in_pixel_index,
  input  logic                            in_frame_start,
  input  logic                            in_table_parity,
  input  logic [pdlb_pkg::IDX_W-1:0]      in_table_index,
  input  logic [pdlb_pkg::COLOUR_W-1:0]   in_table_colour,
  // result items
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [pdlb_pkg::COLOUR_W-1:0]   out_blended_colour,
  output logic                            out_line_last
);
  import pdlb_pkg::*;

  // configuration registers
  logic [LW_W-1:0]     line_width_r;
  logic                start_parity_r;
  logic [COLOUR_W-1:0] avg_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= LINE_WIDTH_RST;
      start_parity_r <= START_PARITY_RST;
      avg_mask_r     <= AVG_MASK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LINE_WIDTH:   line_width_r   <= cfg_wdata[LW_W-1:0];
        CFG_START_PARITY: start_parity_r <= cfg_wdata[0];
        CFG_AVERAGE_MASK: avg_mask_r     <= cfg_wdata;
        default:          ;
      endcase
    end
  end

  // pipeline handshake
  logic s1_valid_r, s2_valid_r, out_valid_r;
  logic adv_out, adv2, adv1, acc, acc_pix, mv2;

  assign adv_out  = !out_valid_r || !out_stall;
  assign adv2     = !s2_valid_r || adv_out;
  assign adv1     = !s1_valid_r || adv2;
  assign in_stall = !adv1;
  assign acc      = in_valid && adv1;
  assign acc_pix  = acc && (req_t'(in_req_type) == REQ_PIXEL);

  // raster sequencer and line store
  logic [COL_W-1:0] col;
  pix_ctl_t         ctl;
  logic [IDX_W-1:0] above_raw;

  pdlb_raster_ctl u_ctl (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc_pix      (acc_pix),
    .frame_start  (in_frame_start),
    .line_width   (line_width_r),
    .start_parity (start_parity_r),
    .col          (col),
    .ctl          (ctl)
  );

  pdlb_line_store u_line (
    .clk   (clk),
    .en    (acc_pix),
    .addr  (col),
    .wdata (in_pixel_index),
    .rdata (above_raw)
  );

  // stage 1 registers
  req_t                s1_type_r;
  pix_ctl_t            s1_ctl_r;
  logic [IDX_W-1:0]    s1_pix_r;
  logic [PAL_AW-1:0]   s1_taddr_r;
  logic [COLOUR_W-1:0] s1_tcolour_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv1) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_type_r    <= req_t'(in_req_type);
      s1_ctl_r     <= ctl;
      s1_pix_r     <= in_pixel_index;
      s1_taddr_r   <= {in_table_parity, in_table_index};
      s1_tcolour_r <= in_table_colour;
    end
  end

  // stage 1: form both palette addresses, or write the palette
  logic [IDX_W-1:0]    above, mixed;
  logic [PAL_AW-1:0]   here_addr, there_addr;
  logic                pal_re, pal_we;
  logic [COLOUR_W-1:0] here, there;

  assign mv2        = s1_valid_r && adv2;
  assign pal_re     = mv2 && (s1_type_r == REQ_PIXEL);
  assign pal_we     = mv2 && (s1_type_r == REQ_TABLE);
  assign above      = s1_ctl_r.first ? s1_pix_r : above_raw;
  assign mixed      = (above & HUE_MASK) | (s1_pix_r & LUMA_MASK);
  assign here_addr  = {s1_ctl_r.parity, s1_pix_r};
  assign there_addr = {~s1_ctl_r.parity, mixed};

  pdlb_palette u_pal (
    .clk     (clk),
    .we      (pal_we),
    .waddr   (s1_taddr_r),
    .wdata   (s1_tcolour_r),
    .re      (pal_re),
    .raddr_a (here_addr),
    .raddr_b (there_addr),
    .rdata_a (here),
    .rdata_b (there)
  );

  // stage 2 registers: only pixels go on
  logic s2_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv2) begin
      s2_valid_r <= s1_valid_r && (s1_type_r == REQ_PIXEL);
    end
  end

  always_ff @(posedge clk) begin
    if (mv2) begin
      s2_last_r <= s1_ctl_r.last;
    end
  end

  // output register holds the blended colour
  logic [COLOUR_W-1:0] out_colour_r;
  logic                out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_out) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && s2_valid_r) begin
      out_colour_r <= blend_colour(here, there, avg_mask_r);
      out_last_r   <= s2_last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_blended_colour = out_colour_r;
  assign out_line_last      = out_last_r;

  // a stall only ever comes from an occupied stage 1
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty pipeline");

  // a pixel waiting behind a stalled output is kept
  a_s2_kept: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && out_valid_r && out_stall |=> s2_valid_r)
    else $error("stage 2 pixel dropped under stall");

  // palette is never read and written in the same cycle
  a_pal_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(pal_re && pal_we))
    else $error("palette read and write collide");

endmodule

[tb/sv/pdlb_blend_checker.sv]
`timescale 1ns / 100ps
// checker for the palette delay-line blend: watches config writes and both item channels,
// predicts each blended pixel and compares it with the block's result; needs pdlb_pkg
module pdlb_blend_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  pdlb_pkg::cfg_idx_t            cfg_index,
  input  logic [pdlb_pkg::COLOUR_W-1:0] cfg_wdata,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          in_req_type,
  input  logic [pdlb_pkg::IDX_W-1:0]    in_pixel_index,
  input  logic                          in_frame_start,
  input  logic                          in_table_parity,
  input  logic [pdlb_pkg::IDX_W-1:0]    in_table_index,
  input  logic [pdlb_pkg::COLOUR_W-1:0] in_table_colour,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [pdlb_pkg::COLOUR_W-1:0] out_blended_colour,
  input  logic                          out_line_last,
  output int                            fail_count,
  output int                            pending
);
  import pdlb_pkg::*;

  typedef struct packed {
    logic [COLOUR_W-1:0] colour;
    logic                last;
  } blend_item_t;

  // shadow of the block state and its registers
  logic [COLOUR_W-1:0] palette [1 << PAL_AW];
  logic [IDX_W-1:0]    line_above [MAX_LINE];
  int unsigned         column;
  logic                parity;
  logic                first_row;
  logic [LW_W-1:0]     width_reg;
  logic                start_par_reg;
  logic [COLOUR_W-1:0] mask_reg;

  blend_item_t blend_q [$];
  int          err_cnt = 0;

  assign fail_count = err_cnt;

  task automatic report_mismatch(string what, logic [COLOUR_W-1:0] got,
                                 logic [COLOUR_W-1:0] want);
    $display("MISMATCH %s at %0t: got %h, expected %h", what, $realtime, got, want);
    err_cnt++;
  endtask

  // width in use after clamping to 1..MAX_LINE
  function automatic int unsigned active_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_LINE) return MAX_LINE;
    return 32'(width_reg);
  endfunction

  // one pixel through the raster state and both palettes
  function automatic blend_item_t blend_pixel(logic [IDX_W-1:0] pix, logic fs);
    blend_item_t        r;
    logic [IDX_W-1:0]   above;
    logic [IDX_W-1:0]   mixed;
    logic [COLOUR_W-1:0] here;
    logic [COLOUR_W-1:0] there;
    int unsigned        w;
    if (fs) begin
      column    = 0;
      parity    = start_par_reg;
      first_row = 1'b1;
    end
    w = active_width();
    if (column >= MAX_LINE) column = 0;
    above = first_row ? pix : line_above[column[COL_W-1:0]];
    mixed = (above & HUE_MASK) | (pix & LUMA_MASK);
    here  = palette[{parity, pix}];
    there = palette[{~parity, mixed}];
    r.colour = (here & there) + (((here ^ there) & mask_reg) >> 1);
    line_above[column[COL_W-1:0]] = pix;
    r.last = (column + 1 >= w);
    if (r.last) begin
      column    = 0;
      parity    = ~parity;
      first_row = 1'b0;
    end else begin
      column++;
    end
    return r;
  endfunction

  initial begin
    for (int i = 0; i < (1 << PAL_AW); i++) palette[i[PAL_AW-1:0]] = '0;
    for (int i = 0; i < MAX_LINE; i++) line_above[i[COL_W-1:0]] = '0;
  end

  always @(posedge clk) begin
    blend_item_t want;
    if (!rst_n) begin
      width_reg     = LINE_WIDTH_RST;
      start_par_reg = START_PARITY_RST;
      mask_reg      = AVG_MASK_RST;
      column        = 0;
      parity        = START_PARITY_RST;
      first_row     = 1'b1;
      blend_q.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_LINE_WIDTH:   width_reg     = cfg_wdata[LW_W-1:0];
          CFG_START_PARITY: start_par_reg = cfg_wdata[0];
          CFG_AVERAGE_MASK: mask_reg      = cfg_wdata;
          default: ;
        endcase
      end
      // accepted input item
      if (in_valid && !in_stall) begin
        if (req_t'(in_req_type) == REQ_TABLE)
          palette[{in_table_parity, in_table_index}] = in_table_colour;
        else
          blend_q.push_back(blend_pixel(in_pixel_index, in_frame_start));
      end
      // accepted result item
      if (out_valid && !out_stall) begin
        if (blend_q.size() == 0) begin
          report_mismatch("unexpected result", out_blended_colour, '0);
        end else begin
          want = blend_q.pop_front();
          if (out_blended_colour !== want.colour)
            report_mismatch("blended_colour", out_blended_colour, want.colour);
          if (out_line_last !== want.last)
            report_mismatch("line_last", COLOUR_W'(out_line_last), COLOUR_W'(want.last));
        end
      end
    end
    pending <= blend_q.size();
  end

endmodule

[tb/sv/pal_delay_line_blend_top_tb.sv]
`timescale 1ns / 100ps
// stimulus and verdict for pal_delay_line_blend_top; the checker module does the prediction
// depends on pdlb_pkg, pal_delay_line_blend_top and pdlb_blend_checker
module pal_delay_line_blend_top_tb;
  import pdlb_pkg::*;

  localparam int RAND_ITEMS   = 850;
  localparam int SETTLE       = 8;
  localparam int WATCHDOG_MAX = 4000;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  cfg_idx_t            cfg_index;
  logic [COLOUR_W-1:0] cfg_wdata;
  logic                in_valid;
  logic                in_stall;
  logic                in_req_type;
  logic [IDX_W-1:0]    in_pixel_index;
  logic                in_frame_start;
  logic                in_table_parity;
  logic [IDX_W-1:0]    in_table_index;
  logic [COLOUR_W-1:0] in_table_colour;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [COLOUR_W-1:0] out_blended_colour;
  logic                out_line_last;
  logic                quiet = 1'b0;
  int                  fail_count;
  int                  pending;
  int                  stuck_cycles = 0;

  pal_delay_line_blend_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_pixel_index     (in_pixel_index),
    .in_frame_start     (in_frame_start),
    .in_table_parity    (in_table_parity),
    .in_table_index     (in_table_index),
    .in_table_colour    (in_table_colour),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_blended_colour (out_blended_colour),
    .out_line_last      (out_line_last)
  );

  pdlb_blend_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_pixel_index     (in_pixel_index),
    .in_frame_start     (in_frame_start),
    .in_table_parity    (in_table_parity),
    .in_table_index     (in_table_index),
    .in_table_colour    (in_table_colour),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_blended_colour (out_blended_colour),
    .out_line_last      (out_line_last),
    .fail_count         (fail_count),
    .pending            (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 13);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles + 1 >= WATCHDOG_MAX) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_MAX);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  // offer one item, holding it until accepted
  task automatic push_item(req_t kind, logic [IDX_W-1:0] pix, logic fs, logic par,
                           logic [IDX_W-1:0] idx, logic [COLOUR_W-1:0] col);
    while (!quiet && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= kind;
    in_pixel_index  <= pix;
    in_frame_start  <= fs;
    in_table_parity <= par;
    in_table_index  <= idx;
    in_table_colour <= col;
    do @(posedge clk); while (in_stall);
  endtask

  // pixel item; palette fields carry noise
  task automatic push_pixel(logic [IDX_W-1:0] pix, logic fs);
    push_item(REQ_PIXEL, pix, fs, 1'($urandom_range(1)), IDX_W'($urandom), $urandom);
  endtask

  // palette write item; pixel fields carry noise
  task automatic push_table(logic par, logic [IDX_W-1:0] idx, logic [COLOUR_W-1:0] col);
    push_item(REQ_TABLE, IDX_W'($urandom), 1'($urandom_range(1)), par, idx, col);
  endtask

  // stop sending until every pixel has its result, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // write all three registers; block must be idle
  task automatic set_config(logic [LW_W-1:0] width, logic sp, logic [COLOUR_W-1:0] mask);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LINE_WIDTH;
    cfg_wdata <= COLOUR_W'(width);
    @(posedge clk);
    cfg_index <= CFG_START_PARITY;
    cfg_wdata <= COLOUR_W'(sp);
    @(posedge clk);
    cfg_index <= CFG_AVERAGE_MASK;
    cfg_wdata <= mask;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int                  rand_items;
    int                  seg;
    int                  n;
    logic [LW_W-1:0]     width;
    logic [COLOUR_W-1:0] mask;

    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_LINE_WIDTH;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    in_req_type     = REQ_PIXEL;
    in_pixel_index  = '0;
    in_frame_start  = 1'b0;
    in_table_parity = 1'b0;
    in_table_index  = '0;
    in_table_colour = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill both palettes, then one full-width first line to fill the line store
    set_config(10'd512, 1'b0, AVG_MASK_RST);
    for (int i = 0; i < (1 << PAL_AW); i++) push_table(i[8], i[7:0], $urandom);
    push_pixel(IDX_W'($urandom), 1'b1);
    repeat (MAX_LINE - 1) push_pixel(IDX_W'($urandom), 1'b0);

    // colour extremes, nibble extremes, frame start in the middle of a line
    push_table(1'b0, 8'h00, 32'h0000_0000);
    push_table(1'b1, 8'hFF, 32'hFFFF_FFFF);
    push_table(1'b0, 8'hFF, 32'hFFFF_FFFF);
    push_table(1'b1, 8'h00, 32'h0000_0000);
    push_pixel(8'h00, 1'b0);
    push_pixel(8'hFF, 1'b0);
    push_pixel(8'h0F, 1'b0);
    push_pixel(8'hF0, 1'b1);
    push_pixel(8'hFF, 1'b0);
    push_pixel(8'h00, 1'b0);

    // zero width acts as one; new start parity waits for the next frame start
    drain();
    set_config(10'd0, 1'b1, 32'h0000_0000);
    push_pixel(IDX_W'($urandom), 1'b0);
    push_pixel(IDX_W'($urandom), 1'b0);
    push_pixel(IDX_W'($urandom), 1'b1);
    push_pixel(IDX_W'($urandom), 1'b0);
    push_pixel(IDX_W'($urandom), 1'b0);

    // width above the line store is clamped
    drain();
    set_config(10'd1023, 1'b0, 32'hFFFF_FFFF);
    push_pixel(IDX_W'($urandom), 1'b1);
    push_pixel(IDX_W'($urandom), 1'b0);
    push_pixel(IDX_W'($urandom), 1'b0);

    // width shrunk behind the current column ends the line at once
    drain();
    set_config(10'd513, 1'b1, AVG_MASK_RST);
    repeat (8) push_pixel(IDX_W'($urandom), 1'b0);
    drain();
    set_config(10'd4, 1'b0, AVG_MASK_RST);
    push_pixel(IDX_W'($urandom), 1'b0);
    push_pixel(IDX_W'($urandom), 1'b0);

    // random segments, each under its own register setting
    rand_items = 0;
    seg = 0;
    while (rand_items < RAND_ITEMS) begin
      drain();
      case ($urandom_range(9))
        0:       width = 10'd0;
        1:       width = 10'd512;
        2:       width = LW_W'($urandom_range(1023, 513));
        3:       width = LW_W'($urandom_range(1023, 1));
        default: width = LW_W'($urandom_range(24, 1));
      endcase
      case ($urandom_range(4))
        0:       mask = 32'h0000_0000;
        1:       mask = 32'hFFFF_FFFF;
        2:       mask = $urandom;
        default: mask = AVG_MASK_RST;
      endcase
      set_config(width, 1'($urandom_range(1)), mask);
      quiet <= (seg == 2);
      n = (seg == 2) ? 300 : $urandom_range(160, 40);
      if ($urandom_range(1)) push_pixel(IDX_W'($urandom), 1'b1);
      repeat (n) begin
        if ($urandom_range(99) < 12)
          push_table(1'($urandom_range(1)), IDX_W'($urandom), $urandom);
        else
          push_pixel(IDX_W'($urandom), $urandom_range(99) < 3);
        if ($urandom_range(249) == 0) drain();
      end
      rand_items += n;
      seg++;
    end

    quiet <= 1'b0;
    drain();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[pal_delay_line_blend_top.f]
rtl/pdlb_pkg.sv
rtl/pdlb_palette.sv
rtl/pdlb_line_store.sv
rtl/pdlb_raster_ctl.sv
rtl/pal_delay_line_blend_top.sv
tb/sv/pdlb_blend_checker.sv
tb/sv/pal_delay_line_blend_top_tb.sv
